[hdl/lmd_pkg.sv]
// Shared types, constants and the digit font for the LED matrix frame buffer.
package lmd_pkg;

  localparam int FRAME_WIDTH  = 24;
  localparam int FRAME_HEIGHT = 8;
  localparam int TILE_SIZE    = 8;
  localparam int NUM_TILES    = FRAME_WIDTH / TILE_SIZE;
  localparam int DEPTH        = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int COLOR_W      = 24;
  localparam int XW           = 7;
  localparam int YW           = 6;
  localparam int OFS_W        = 5;
  localparam int KCNT_W       = 6;
  localparam int TILE_W       = 2;
  localparam int NT_W         = $clog2(NUM_TILES + 1);
  localparam int DATA_W       = 32;
  localparam int PADDR_W      = 3;

  localparam logic [PADDR_W-3:0] REG_SCAN_ORDER = '0;

  typedef enum logic [2:0] {
    KIND_PIXEL  = 3'd0,
    KIND_COLUMN = 3'd1,
    KIND_DIGIT  = 3'd2,
    KIND_HRUN   = 3'd3,
    KIND_VRUN   = 3'd4,
    KIND_SCAN   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DRAW = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  // 3x5 font, one 5-bit column per call; digits above nine draw zero
  function automatic logic [4:0] digit_font(input logic [3:0] dg, input logic [1:0] col);
    logic [14:0] g;
    case (dg)
      4'd1:    g = {5'h1F, 5'h00, 5'h00};
      4'd2:    g = {5'h17, 5'h15, 5'h1D};
      4'd3:    g = {5'h1F, 5'h15, 5'h15};
      4'd4:    g = {5'h1F, 5'h04, 5'h07};
      4'd5:    g = {5'h1D, 5'h15, 5'h17};
      4'd6:    g = {5'h1D, 5'h15, 5'h1F};
      4'd7:    g = {5'h1F, 5'h01, 5'h01};
      4'd8:    g = {5'h1F, 5'h15, 5'h1F};
      4'd9:    g = {5'h1F, 5'h15, 5'h17};
      default: g = {5'h1F, 5'h11, 5'h1F};
    endcase
    case (col)
      2'd0:    digit_font = g[4:0];
      2'd1:    digit_font = g[9:5];
      2'd2:    digit_font = g[14:10];
      default: digit_font = 5'h00;
    endcase
  endfunction

endpackage

[hdl/led_matrix_draw_and_tiled_scanout.sv]
// Top level: LED matrix frame buffer with draw commands and tiled scan-out.
// Draw item: one visited position per cycle (pixel 1, column 8, digit 15, runs
// run_length+1), then back to idle for the next accept; single memory write port.
// Scan item: each pixel passes the registered read stage, then the output register; one
// per cycle while out_ready does not stall them; next accept once all 64 are read.
// Sync active-low reset: valid flops clear so the frame reads zero; scan_order resets to 1.
module led_matrix_draw_and_tiled_scanout (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_kind,
  input  logic [4:0]                        in_x_pos,
  input  logic [3:0]                        in_y_pos,
  input  logic [3:0]                        in_digit,
  input  logic [7:0]                        in_column_bits,
  input  logic [4:0]                        in_run_length,
  input  logic [lmd_pkg::COLOR_W-1:0]       in_pixel_color,
  input  logic [lmd_pkg::TILE_W-1:0]        in_tile,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_led_index,
  output logic [lmd_pkg::COLOR_W-1:0]       out_led_color,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lmd_pkg::PADDR_W-1:0]       paddr,
  input  logic [lmd_pkg::DATA_W-1:0]        pwdata,
  output logic [lmd_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  lmd_pkg::state_t                     state_r, state_nxt;
  lmd_pkg::kind_t                      kind_r;
  logic [4:0]                          x_r;
  logic [3:0]                          y_r;
  logic [3:0]                          digit_r;
  logic [7:0]                          bits_r;
  logic [4:0]                          len_r;
  logic [lmd_pkg::COLOR_W-1:0]         color_r;
  logic [lmd_pkg::TILE_W-1:0]          tile_r;
  logic [lmd_pkg::OFS_W-1:0]           a_r, a_nxt, b_r, b_nxt;
  logic [lmd_pkg::KCNT_W-1:0]          k_r, k_nxt;
  logic                                scan_order_r;

  logic [lmd_pkg::COLOR_W-1:0]         mem [lmd_pkg::DEPTH];
  logic [lmd_pkg::DEPTH-1:0]           vld_r;
  logic [lmd_pkg::COLOR_W-1:0]         rdata_r;
  logic                                rvld_r;
  logic                                s1_v_r;
  logic [7:0]                          s1_idx_r;
  logic                                s1_last_r;

  logic                                out_valid_r;
  logic [7:0]                          out_idx_r;
  logic [lmd_pkg::COLOR_W-1:0]         out_color_r;
  logic                                out_last_r;

  logic                                in_acc, cfg_wr, adv, rd_en, we, paint, step_last;
  logic [lmd_pkg::XW-1:0]              px, sx;
  logic [lmd_pkg::YW-1:0]              py;
  logic [2:0]                          srow, scol, btile;
  logic [lmd_pkg::ADDR_W-1:0]          waddr, raddr;
  logic [4:0]                          font_col;

  assign in_ready = (state_r == lmd_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[lmd_pkg::PADDR_W-1:2] == lmd_pkg::REG_SCAN_ORDER) ?
                    {{(lmd_pkg::DATA_W-1){1'b0}}, scan_order_r} : '0;

  // draw step: current painted position
  assign px       = lmd_pkg::XW'(x_r) + lmd_pkg::XW'(a_r);
  assign py       = lmd_pkg::YW'(y_r) + lmd_pkg::YW'(b_r);
  assign font_col = lmd_pkg::digit_font(digit_r, a_r[1:0]);
  assign waddr    = lmd_pkg::ADDR_W'(py[2:0]) * lmd_pkg::ADDR_W'(lmd_pkg::FRAME_WIDTH)
                  + lmd_pkg::ADDR_W'(px);

  always_comb begin
    paint     = 1'b1;
    step_last = 1'b1;
    case (kind_r)
      lmd_pkg::KIND_COLUMN: begin
        paint     = bits_r[b_r[2:0]];
        step_last = (b_r == lmd_pkg::OFS_W'(7));
      end
      lmd_pkg::KIND_DIGIT: begin
        paint     = font_col[b_r[2:0]];
        step_last = (a_r == lmd_pkg::OFS_W'(2)) && (b_r == lmd_pkg::OFS_W'(4));
      end
      lmd_pkg::KIND_HRUN: step_last = (a_r == len_r);
      lmd_pkg::KIND_VRUN: step_last = (b_r == len_r);
      default: begin
        paint     = 1'b1;
        step_last = 1'b1;
      end
    endcase
  end

  assign we = (state_r == lmd_pkg::ST_DRAW) && paint &&
              (px < lmd_pkg::XW'(lmd_pkg::FRAME_WIDTH)) &&
              (py < lmd_pkg::YW'(lmd_pkg::FRAME_HEIGHT));

  // scan: chain position k of tile_r
  assign adv   = !out_valid_r || out_ready;
  assign rd_en = (state_r == lmd_pkg::ST_SCAN) && adv;
  assign btile = scan_order_r ? 3'(lmd_pkg::NUM_TILES - 1) - 3'(tile_r) : 3'(tile_r);
  assign srow  = scan_order_r ? ~k_r[5:3] : k_r[5:3];
  assign scol  = scan_order_r ? ~k_r[2:0] : k_r[2:0];
  assign sx    = lmd_pkg::XW'({btile, 3'b000}) + lmd_pkg::XW'(scol);
  assign raddr = lmd_pkg::ADDR_W'(srow) * lmd_pkg::ADDR_W'(lmd_pkg::FRAME_WIDTH)
               + lmd_pkg::ADDR_W'(sx);

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    case (state_r)
      lmd_pkg::ST_IDLE: begin
        a_nxt = '0;
        b_nxt = '0;
        k_nxt = '0;
        if (in_acc) begin
          case (lmd_pkg::kind_t'(in_kind))
            lmd_pkg::KIND_PIXEL, lmd_pkg::KIND_COLUMN, lmd_pkg::KIND_DIGIT,
            lmd_pkg::KIND_HRUN, lmd_pkg::KIND_VRUN:
              state_nxt = lmd_pkg::ST_DRAW;
            lmd_pkg::KIND_SCAN:
              if (lmd_pkg::NT_W'(in_tile) < lmd_pkg::NT_W'(lmd_pkg::NUM_TILES)) begin
                state_nxt = lmd_pkg::ST_SCAN;
              end
            default: state_nxt = lmd_pkg::ST_IDLE;
          endcase
        end
      end
      lmd_pkg::ST_DRAW: begin
        if (step_last) begin
          state_nxt = lmd_pkg::ST_IDLE;
        end else begin
          case (kind_r)
            lmd_pkg::KIND_DIGIT: begin
              if (b_r == lmd_pkg::OFS_W'(4)) begin
                b_nxt = '0;
                a_nxt = a_r + 1'b1;
              end else begin
                b_nxt = b_r + 1'b1;
              end
            end
            lmd_pkg::KIND_HRUN: a_nxt = a_r + 1'b1;
            default:            b_nxt = b_r + 1'b1;
          endcase
        end
      end
      lmd_pkg::ST_SCAN: begin
        if (rd_en) begin
          k_nxt = k_r + 1'b1;
          if (&k_r) begin
            state_nxt = lmd_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = lmd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lmd_pkg::ST_IDLE;
      scan_order_r <= 1'b1;
      vld_r        <= '0;
      s1_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && (paddr[lmd_pkg::PADDR_W-1:2] == lmd_pkg::REG_SCAN_ORDER)) begin
        scan_order_r <= pwdata[0];
      end
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (adv) begin
        s1_v_r      <= rd_en;
        out_valid_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
    if (in_acc) begin
      kind_r  <= lmd_pkg::kind_t'(in_kind);
      x_r     <= in_x_pos;
      y_r     <= in_y_pos;
      digit_r <= in_digit;
      bits_r  <= in_column_bits;
      len_r   <= in_run_length;
      color_r <= in_pixel_color;
      tile_r  <= in_tile;
    end
  end

  // frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= color_r;
    end
    if (rd_en) begin
      rdata_r   <= mem[raddr];
      rvld_r    <= vld_r[raddr];
      s1_idx_r  <= {tile_r, k_r};
      s1_last_r <= &k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r   <= s1_idx_r;
      out_last_r  <= s1_last_r;
      out_color_r <= rvld_r ? rdata_r : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_index = out_idx_r;
  assign out_led_color = out_color_r;
  assign out_last      = out_last_r;

endmodule
